[rtl/acd_pkg.sv]
// Shared types, constants and helpers for the audio click detect and repair block.
// Depends on nothing; every other file of the block imports it.
package acd_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int MAX_RUN_LIMIT = 128;
   localparam int RING_DEPTH    = MAX_RUN_LIMIT + 16;
   localparam int IDX_BITS      = $clog2(RING_DEPTH);
   localparam int WARMUP_BITS   = 12;
   localparam int WARMUP_SAMPLES = 2048;
   localparam int SCALE_BITS    = 40;
   localparam int SCALE_FRAC    = 14;
   localparam int ERR_BITS      = SAMPLE_BITS + 2;
   localparam int FACTOR_BITS   = 13;
   localparam int PROD_BITS     = SCALE_BITS + FACTOR_BITS;
   localparam int DIV_BITS      = SAMPLE_BITS + 1;
   localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 9;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ENABLE      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SENSITIVITY = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_REPAIR  = 2'd2;

   localparam logic [SCALE_BITS-1:0] SCALE_FLOOR = SCALE_BITS'(1) << SCALE_FRAC;
   localparam logic [SCALE_BITS-1:0] SCALE_MAX   = '1;
   localparam logic [FACTOR_BITS-1:0] DELTA_MULT = FACTOR_BITS'(41);
   localparam int DELTA_SHIFT = 13;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_PREV,
      ST_RD_BEF,
      ST_MUL_THR,
      ST_MUL_DELTA,
      ST_UPDATE,
      ST_CHECK,
      ST_SCAN,
      ST_ISSUE_END,
      ST_RD_END,
      ST_DIV,
      ST_INTERP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                clear;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      logic [IDX_BITS-1:0] rd_addr;
   } ring_ctrl_type;

   // Next slot of a ring whose current length is cap.
   function automatic logic [IDX_BITS-1:0] ring_inc(input logic [IDX_BITS-1:0] idx,
                                                    input logic [IDX_BITS-1:0] cap);
      logic [IDX_BITS-1:0] nxt;
      nxt = idx + IDX_BITS'(1);
      return (nxt == cap) ? '0 : nxt;
   endfunction

endpackage

[rtl/acd_ring.sv]
// Sample ring memory with one write and one registered read port.
// Per-entry valid bits make never-written entries read as zero. Uses acd_pkg.
module acd_ring (
   input  logic                               clock,
   input  logic                               reset,
   input  acd_pkg::ring_ctrl_type             ctrl,
   input  logic signed [acd_pkg::SAMPLE_BITS-1:0] wr_data,
   output logic signed [acd_pkg::SAMPLE_BITS-1:0] rd_data
);
   import acd_pkg::*;

   logic signed [SAMPLE_BITS-1:0] mem [RING_DEPTH];
   logic [RING_DEPTH-1:0]         valid_ff;
   logic [RING_DEPTH-1:0]         valid_in;
   logic signed [SAMPLE_BITS-1:0] rd_ff;
   logic                          rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      rd_ff <= mem[ctrl.rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.wr_en) begin
         valid_in[ctrl.wr_addr] = 1'b1;
      end
      if (ctrl.clear) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

[rtl/acd_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Used for the slope of the interpolation. Uses acd_pkg.
module acd_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [acd_pkg::DIV_BITS-1:0]      dividend,
   input  logic [acd_pkg::IDX_BITS-1:0]      divisor,
   output logic                              done,
   output logic [acd_pkg::DIV_BITS-1:0]      quotient,
   output logic [acd_pkg::IDX_BITS-1:0]      remainder
);
   import acd_pkg::*;

   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [IDX_BITS-1:0]     rem_ff, rem_in;
   logic [IDX_BITS-1:0]     dsor_ff, dsor_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [IDX_BITS:0]       trial;
   logic                    fits;

   assign trial = {rem_ff, quo_ff[DIV_BITS-1]};
   assign fits  = trial >= {1'b0, dsor_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsor_in = divisor;
         cnt_in  = DIV_CNT_BITS'(DIV_BITS);
      end else if (cnt_ff != '0) begin
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? IDX_BITS'(trial - {1'b0, dsor_ff}) : IDX_BITS'(trial);
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         done_in = (cnt_ff == DIV_CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/audio_click_detect_repair_top.sv]
// Top level of the audio click detector and repairer: sequencer, tracker and config.
// Instantiates acd_ring and acd_div; uses acd_pkg.
//
// One signed sample goes in per item and one delayed, possibly repaired sample comes
// out per item. The block handles one item at a time: req_stall is high from the
// cycle after an item is accepted until its result has been loaded into the output
// register, and that register lets the next item be accepted while the result still
// waits on rsp_stall. A disabled item goes straight from idle to the finish state. An
// enabled item steps through the read, multiply, update and check states. When the read
// slot is flagged, the flagged run is scanned one flag per cycle, the slope is found by a
// bit-serial divider in 25 steps that the sequencer waits out, and the run is rewritten
// one sample per cycle through the single ring write port. The error tracker shares one
// multiplier between the threshold and the tracker step. Writing max_repair clears the
// ring, the flags and the tracker at once; there is no clearing pass.
module audio_click_detect_repair_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [acd_pkg::SAMPLE_BITS-1:0]   req_sample_in,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [acd_pkg::SAMPLE_BITS-1:0]   rsp_sample_out,
   output logic                                     rsp_repair_started,
   input  logic                                     csr_we,
   input  logic [acd_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [acd_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);
   import acd_pkg::*;

   // Configuration registers.
   logic       enable_ff;
   logic [8:0] sens_ff;
   logic [7:0] maxrep_ff;
   logic       clear;

   // Sequencer and datapath registers.
   state_type                     state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] p_ff, p_in;
   logic [ERR_BITS-1:0]           err_ff, err_in;
   logic [PROD_BITS-1:0]          prod_ff, prod_in;
   logic                          over_ff, over_in;
   logic [SCALE_BITS-1:0]         scale_ff, scale_in;
   logic [WARMUP_BITS-1:0]        warm_ff, warm_in;
   logic [IDX_BITS-1:0]           wr_idx_ff, wr_idx_in;
   logic [IDX_BITS-1:0]           wslot_ff, wslot_in;
   logic [IDX_BITS-1:0]           rd_ff, rd_in;
   logic [RING_DEPTH-1:0]         flag_ff, flag_in;
   logic                          inside_ff, inside_in;
   logic signed [SAMPLE_BITS-1:0] lastout_ff, lastout_in;
   logic signed [SAMPLE_BITS-1:0] raw_ff, raw_in;
   logic [IDX_BITS-1:0]           run_ff, run_in;
   logic [IDX_BITS-1:0]           scan_ff, scan_in;
   logic [IDX_BITS-1:0]           at_ff, at_in;
   logic [IDX_BITS-1:0]           k_ff, k_in;
   logic signed [SAMPLE_BITS-1:0] start_ff, start_in;
   logic                          dneg_ff, dneg_in;
   logic signed [DIV_BITS:0]      qs_ff, qs_in;
   logic [IDX_BITS:0]             rs_ff, rs_in;
   logic signed [DIV_BITS:0]      q_ff, q_in;
   logic [IDX_BITS+1:0]           r_ff, r_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic                          started_ff, started_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_started_ff;

   // Ring and divider connections.
   ring_ctrl_type                 ring_ctrl;
   logic signed [SAMPLE_BITS-1:0] ring_wdata;
   logic signed [SAMPLE_BITS-1:0] ring_rdata;
   logic                          div_start;
   logic                          div_done;
   logic [DIV_BITS-1:0]           div_dividend;
   logic [DIV_BITS-1:0]           div_quo;
   logic [IDX_BITS-1:0]           div_rem;

   // Combinational helpers.
   logic [IDX_BITS-1:0]           mrun;
   logic [IDX_BITS-1:0]           cap;
   logic [IDX_BITS-1:0]           prev_idx;
   logic [IDX_BITS-1:0]           bef_idx;
   logic [IDX_BITS-1:0]           w_next;
   logic [IDX_BITS-1:0]           scan_next;
   logic                          scan_go;
   logic                          scan_stop;
   logic [IDX_BITS-1:0]           run_after;
   logic [8:0]                    sens_sat;
   logic [FACTOR_BITS-1:0]        factor;
   logic [FACTOR_BITS-1:0]        mul_b;
   logic signed [ERR_BITS:0]      diff;
   logic [SCALE_BITS-1:0]         delta;
   logic [SCALE_BITS:0]           scale_up;
   logic [SCALE_BITS-1:0]         scale_dn;
   logic                          flagged;
   logic signed [DIV_BITS-1:0]    dspan;
   logic [IDX_BITS-1:0]           dsor;
   logic [IDX_BITS+1:0]           r_step;
   logic [IDX_BITS+1:0]           two_d;
   logic signed [DIV_BITS:0]      q_step;
   logic signed [SAMPLE_BITS-1:0] interp_val;
   logic                          out_free;

   // ------------------------------------------------------------------
   // Configuration port.
   // ------------------------------------------------------------------
   assign clear = csr_we && (csr_index == CSR_MAX_REPAIR);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         sens_ff   <= 9'd128;
         maxrep_ff <= 8'd32;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:      enable_ff <= csr_wdata[0];
            CSR_SENSITIVITY: sens_ff   <= csr_wdata;
            CSR_MAX_REPAIR:  maxrep_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Run limit is clamped to [8, MAX_RUN_LIMIT]; the ring is 16 slots longer.
   assign mrun = (maxrep_ff < 8'd8) ? IDX_BITS'(8) :
                 (maxrep_ff > 8'(MAX_RUN_LIMIT)) ? IDX_BITS'(MAX_RUN_LIMIT) :
                 IDX_BITS'(maxrep_ff);
   assign cap  = mrun + IDX_BITS'(16);

   assign prev_idx  = (wr_idx_ff == '0) ? cap - IDX_BITS'(1) : wr_idx_ff - IDX_BITS'(1);
   assign bef_idx   = (wr_idx_ff >= IDX_BITS'(2)) ? wr_idx_ff - IDX_BITS'(2) :
                      wr_idx_ff + cap - IDX_BITS'(2);
   assign w_next    = ring_inc(wr_idx_ff, cap);
   assign scan_next = ring_inc(scan_ff, cap);
   assign scan_go   = (run_ff <= mrun) && flag_ff[scan_ff];
   // The scan never walks onto the slot just written.
   assign scan_stop = !scan_go || (scan_next == wslot_ff);
   assign run_after = scan_go ? run_ff + IDX_BITS'(1) : run_ff;

   // Threshold factor in Q8 runs from 20.0 down to 4.0.
   assign sens_sat = (sens_ff > 9'd256) ? 9'd256 : sens_ff;
   assign factor   = FACTOR_BITS'(5120) - FACTOR_BITS'({sens_sat, 4'b0000});

   // The one multiplier serves the threshold and then the tracker step.
   assign mul_b   = (state_ff == ST_MUL_THR) ? factor : DELTA_MULT;
   assign prod_in = PROD_BITS'(scale_ff) * PROD_BITS'(mul_b);

   // Second-difference prediction error.
   assign diff = (ERR_BITS+1)'(x_ff) - ((ERR_BITS+1)'(p_ff) <<< 1)
                 + (ERR_BITS+1)'(ring_rdata);

   assign delta    = prod_ff[DELTA_SHIFT +: SCALE_BITS];
   assign scale_up = {1'b0, scale_ff} + {1'b0, delta};
   assign scale_dn = scale_ff - delta;
   assign flagged  = (warm_ff == '0) && over_ff;

   // Interpolation span, divisor and one incremental step of the quotient.
   assign dspan = DIV_BITS'(ring_rdata) - DIV_BITS'(lastout_ff);
   assign div_dividend = dspan[DIV_BITS-1] ? DIV_BITS'(-dspan) : DIV_BITS'(dspan);
   assign dsor  = run_ff + IDX_BITS'(1);
   assign two_d = {1'b0, dsor, 1'b0};

   always_comb begin
      r_step = r_ff + (IDX_BITS+2)'(rs_ff);
      q_step = q_ff + qs_ff;
      if (r_step >= two_d) begin
         r_step = r_step - two_d;
         q_step = q_step + (DIV_BITS+1)'(1);
      end
   end

   assign interp_val = start_ff + SAMPLE_BITS'(q_step);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = enable_ff ? ST_RD_PREV : ST_FINISH;
            end
         end
         ST_RD_PREV:   state_in = ST_RD_BEF;
         ST_RD_BEF:    state_in = ST_MUL_THR;
         ST_MUL_THR:   state_in = ST_MUL_DELTA;
         ST_MUL_DELTA: state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_CHECK;
         ST_CHECK:     state_in = flag_ff[rd_ff] ? ST_SCAN : ST_FINISH;
         ST_SCAN: begin
            if (scan_stop) begin
               state_in = (run_after > mrun) ? ST_FINISH : ST_ISSUE_END;
            end
         end
         ST_ISSUE_END: state_in = ST_RD_END;
         ST_RD_END:    state_in = ST_DIV;
         ST_DIV:       state_in = div_done ? ST_INTERP : ST_DIV;
         ST_INTERP:    state_in = (k_ff == run_ff) ? ST_FINISH : ST_INTERP;
         ST_FINISH:    state_in = out_free ? ST_IDLE : ST_FINISH;
         default:      state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath and control outputs of the sequencer.
   // ------------------------------------------------------------------
   always_comb begin
      x_in       = x_ff;
      p_in       = p_ff;
      err_in     = err_ff;
      over_in    = over_ff;
      scale_in   = scale_ff;
      warm_in    = warm_ff;
      wr_idx_in  = wr_idx_ff;
      wslot_in   = wslot_ff;
      rd_in      = rd_ff;
      flag_in    = flag_ff;
      inside_in  = inside_ff;
      lastout_in = lastout_ff;
      raw_in     = raw_ff;
      run_in     = run_ff;
      scan_in    = scan_ff;
      at_in      = at_ff;
      k_in       = k_ff;
      start_in   = start_ff;
      dneg_in    = dneg_ff;
      qs_in      = qs_ff;
      rs_in      = rs_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      y_in       = y_ff;
      started_in = started_ff;
      div_start  = 1'b0;
      ring_ctrl.clear   = clear;
      ring_ctrl.wr_en   = 1'b0;
      ring_ctrl.wr_addr = at_ff;
      ring_ctrl.rd_addr = rd_ff;
      ring_wdata        = interp_val;

      unique case (state_ff)
         ST_IDLE: begin
            ring_ctrl.rd_addr = prev_idx;
            x_in       = req_sample_in;
            y_in       = req_sample_in;
            started_in = 1'b0;
         end
         ST_RD_PREV: begin
            ring_ctrl.rd_addr = bef_idx;
            p_in = ring_rdata;
         end
         ST_RD_BEF: begin
            err_in = diff[ERR_BITS] ? ERR_BITS'(-diff) : ERR_BITS'(diff);
         end
         ST_MUL_THR: ;
         ST_MUL_DELTA: begin
            over_in = {PROD_BITS'(err_ff), 22'b0} > {22'b0, prod_ff};
         end
         ST_UPDATE: begin
            if ({err_ff, SCALE_FRAC'(0)} > scale_ff) begin
               scale_in = scale_up[SCALE_BITS] ? SCALE_MAX : scale_up[SCALE_BITS-1:0];
            end else begin
               scale_in = (scale_dn < SCALE_FLOOR) ? SCALE_FLOOR : scale_dn;
            end
            if (warm_ff != '0) begin
               warm_in = warm_ff - WARMUP_BITS'(1);
            end
            ring_ctrl.wr_en   = 1'b1;
            ring_ctrl.wr_addr = wr_idx_ff;
            ring_wdata        = x_ff;
            flag_in[wr_idx_ff] = flagged;
            wslot_in  = wr_idx_ff;
            wr_idx_in = w_next;
            rd_in     = w_next;
            ring_ctrl.rd_addr = w_next;
         end
         ST_CHECK: begin
            raw_in = ring_rdata;
            if (!flag_ff[rd_ff]) begin
               inside_in  = 1'b0;
               y_in       = ring_rdata;
               lastout_in = ring_rdata;
            end
            run_in  = '0;
            scan_in = rd_ff;
         end
         ST_SCAN: begin
            run_in = run_after;
            if (scan_go) begin
               scan_in = scan_next;
            end
            if (scan_stop) begin
               if (run_after > mrun) begin
                  // Overlong run: emitted raw, flags stay set.
                  inside_in  = 1'b1;
                  y_in       = raw_ff;
                  lastout_in = raw_ff;
               end else begin
                  started_in = !inside_ff;
                  inside_in  = 1'b1;
               end
            end
         end
         ST_ISSUE_END: begin
            ring_ctrl.rd_addr = scan_ff;
         end
         ST_RD_END: begin
            start_in  = lastout_ff;
            dneg_in   = dspan[DIV_BITS-1];
            div_start = 1'b1;
         end
         ST_DIV: begin
            // Floor division of the span by run + 1, sign handled here.
            if (!dneg_ff) begin
               qs_in = (DIV_BITS+1)'(div_quo);
               rs_in = {div_rem, 1'b0};
            end else if (div_rem != '0) begin
               qs_in = -(DIV_BITS+1)'(div_quo) - (DIV_BITS+1)'(1);
               rs_in = {dsor - div_rem, 1'b0};
            end else begin
               qs_in = -(DIV_BITS+1)'(div_quo);
               rs_in = '0;
            end
            q_in  = '0;
            r_in  = (IDX_BITS+2)'(dsor);
            k_in  = IDX_BITS'(1);
            at_in = rd_ff;
         end
         ST_INTERP: begin
            ring_ctrl.wr_en   = 1'b1;
            ring_ctrl.wr_addr = at_ff;
            flag_in[at_ff]    = 1'b0;
            q_in  = q_step;
            r_in  = r_step;
            k_in  = k_ff + IDX_BITS'(1);
            at_in = ring_inc(at_ff, cap);
            if (k_ff == IDX_BITS'(1)) begin
               y_in       = interp_val;
               lastout_in = interp_val;
            end
         end
         ST_FINISH: ;
         default: ;
      endcase

      // A write to max_repair restarts detection from a clean state.
      if (clear) begin
         flag_in    = '0;
         wr_idx_in  = '0;
         scale_in   = SCALE_FLOOR;
         warm_in    = WARMUP_BITS'(WARMUP_SAMPLES);
         inside_in  = 1'b0;
         lastout_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scale_ff     <= SCALE_FLOOR;
         warm_ff      <= WARMUP_BITS'(WARMUP_SAMPLES);
         wr_idx_ff    <= '0;
         flag_ff      <= '0;
         inside_ff    <= 1'b0;
         lastout_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         warm_ff      <= warm_in;
         wr_idx_ff    <= wr_idx_in;
         flag_ff      <= flag_in;
         inside_ff    <= inside_in;
         lastout_ff   <= lastout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff       <= x_in;
      p_ff       <= p_in;
      err_ff     <= err_in;
      prod_ff    <= prod_in;
      over_ff    <= over_in;
      wslot_ff   <= wslot_in;
      rd_ff      <= rd_in;
      raw_ff     <= raw_in;
      run_ff     <= run_in;
      scan_ff    <= scan_in;
      at_ff      <= at_in;
      k_ff       <= k_in;
      start_ff   <= start_in;
      dneg_ff    <= dneg_in;
      qs_ff      <= qs_in;
      rs_ff      <= rs_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      y_ff       <= y_in;
      started_ff <= started_in;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_sample_ff  <= y_ff;
         rsp_started_ff <= started_ff;
      end
   end

   acd_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ring_ctrl),
      .wr_data (ring_wdata),
      .rd_data (ring_rdata)
   );

   acd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (dsor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_repair_started = rsp_started_ff;

endmodule

[rtl/acd_checker.sv]
// Port-level checks of the click repair block over time, bound to its top level.
// Sees only the top level's ports; uses acd_pkg for widths.
module acd_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic signed [acd_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [acd_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                                   rsp_repair_started,
   input logic                                   csr_we,
   input logic [acd_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input logic [acd_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import acd_pkg::*;

   // One item at a time: an accepted item blocks the input on the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted on two consecutive cycles");

   // Nothing comes out right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sample_out) && $stable(rsp_repair_started))
      else $error("stalled result changed");

endmodule

bind audio_click_detect_repair_top acd_checker u_acd_checker (.*);

[tb/tb_audio_click_detect_repair_top.sv]
// Testbench for audio_click_detect_repair_top: a click repair predictor, random stimulus
// with clicks, and a checker on the output channel. Depends on rtl/acd_pkg.sv and the RTL.
`timescale 1ns / 1ps

module tb_audio_click_detect_repair_top;
   import acd_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_repair_started;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]       csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;

   audio_click_detect_repair_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_out(rsp_sample_out),
      .rsp_repair_started(rsp_repair_started),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // One expected output item.
   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          started;
   } repaired_type;

   repaired_type repaired_q[$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           hold_request = 0;

   // Shadow of the block's state and registers, kept in step with every accepted item.
   logic signed [SAMPLE_BITS-1:0] shadow_ring [RING_DEPTH];
   bit                            shadow_flag [RING_DEPTH];
   int unsigned                   shadow_wr;
   longint unsigned               shadow_scale;
   int unsigned                   shadow_warmup;
   bit                            shadow_in_run;
   longint                        shadow_last;
   bit                            cfg_enable;
   int unsigned                   cfg_sensitivity;
   int unsigned                   cfg_max_repair;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
               what, cycle_count, got, want);
      error_count++;
   endtask

   function automatic void clear_shadow();
      foreach (shadow_ring[i]) begin
         shadow_ring[i] = '0;
         shadow_flag[i] = 1'b0;
      end
      shadow_wr     = 0;
      shadow_scale  = longint'(SCALE_FLOOR);
      shadow_warmup = WARMUP_SAMPLES;
      shadow_in_run = 1'b0;
      shadow_last   = 0;
   endfunction

   // Linear fill value k of d-1 slots between two ends, halves rounded upward.
   function automatic longint fill_value(input longint a, input longint b,
                                         input int unsigned k, input int unsigned d);
      longint n2, den, q;
      n2  = 2 * (b - a) * longint'(k) + longint'(d);
      den = 2 * longint'(d);
      q   = (n2 >= 0) ? n2 / den : -((-n2 + den - 1) / den);
      return a + q;
   endfunction

   // Works out the output of one accepted sample and advances the shadow state.
   function automatic repaired_type repair_sample(input logic signed [SAMPLE_BITS-1:0] x);
      repaired_type    res;
      int unsigned     mrun, cap, w, prv, bef, s, run, scan, at;
      longint          diff, y;
      longint unsigned err, factor, delta;
      bit              over, flagged;
      res.started = 1'b0;
      if (!cfg_enable) begin
         res.sample = x;
         return res;
      end
      mrun = (cfg_max_repair < 8) ? 8 : (cfg_max_repair > MAX_RUN_LIMIT) ? MAX_RUN_LIMIT
           : cfg_max_repair;
      cap  = mrun + 16;
      w    = shadow_wr % cap;
      prv  = (w + cap - 1) % cap;
      bef  = (w + cap - 2) % cap;
      diff = longint'(x) - (2 * longint'(shadow_ring[prv]) - longint'(shadow_ring[bef]));
      err  = (diff < 0) ? -diff : diff;
      s      = (cfg_sensitivity > 256) ? 256 : cfg_sensitivity;
      factor = 5120 - 16 * s;
      over   = (err << 22) > shadow_scale * factor;
      delta  = (shadow_scale * 41) >> DELTA_SHIFT;
      if ((err << SCALE_FRAC) > shadow_scale) begin
         shadow_scale += delta;
         if (shadow_scale > longint'(SCALE_MAX)) shadow_scale = longint'(SCALE_MAX);
      end else begin
         shadow_scale -= delta;
         if (shadow_scale < longint'(SCALE_FLOOR)) shadow_scale = longint'(SCALE_FLOOR);
      end
      flagged = 1'b0;
      if (shadow_warmup > 0) shadow_warmup--;
      else flagged = over;
      shadow_ring[w] = x;
      shadow_flag[w] = flagged;
      shadow_wr      = (w + 1) % cap;
      if (!shadow_flag[shadow_wr]) begin
         shadow_in_run = 1'b0;
      end else begin
         run  = 0;
         scan = shadow_wr;
         while (run <= mrun && shadow_flag[scan]) begin
            run++;
            scan = (scan + 1) % cap;
            if (scan == w) break;
         end
         // An overlong run goes out raw with its flags left set.
         if (run <= mrun) begin
            res.started = !shadow_in_run;
            at = shadow_wr;
            for (int unsigned k = 1; k <= run; k++) begin
               shadow_ring[at] = fill_value(shadow_last, longint'(shadow_ring[scan]), k,
                                            run + 1);
               shadow_flag[at] = 1'b0;
               at = (at + 1) % cap;
            end
         end
         shadow_in_run = 1'b1;
      end
      y           = longint'(shadow_ring[shadow_wr]);
      shadow_last = y;
      res.sample  = y[SAMPLE_BITS-1:0];
      return res;
   endfunction

   // Offers one item, with random idle cycles ahead of it, and predicts it on acceptance.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall !== 1'b0);
      repaired_q.push_back(repair_sample(x));
   endtask

   // Lowers valid and waits until every expected item has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (repaired_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Register writes happen only with the block drained.
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input int unsigned val);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ENABLE:      cfg_enable = val[0];
         CSR_SENSITIVITY: cfg_sensitivity = val & 9'h1FF;
         CSR_MAX_REPAIR: begin
            cfg_max_repair = val & 8'hFF;
            clear_shadow();
         end
         default: ;
      endcase
   endtask

   // Quiet noise, then noise with clicks of random length, some past the repair limit.
   // Clicks are only flagged once the warm-up count has run out.
   task automatic send_audio(input int warm_count, input int click_count, input int mrun);
      int                            left, run_len;
      logic signed [SAMPLE_BITS-1:0] x;
      for (int i = 0; i < warm_count; i++)
         send_sample(SAMPLE_BITS'($signed($urandom_range(400)) - 200));
      left = 0;
      for (int i = 0; i < click_count; i++) begin
         if (left == 0 && $urandom_range(99) < 4) begin
            run_len = ($urandom_range(3) == 0) ? mrun + 1 + $urandom_range(9)
                    : $urandom_range(mrun, 1);
            left = run_len;
         end
         if (left > 0) begin
            case ($urandom_range(3))
               0:       x = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
               1:       x = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
               default: x = SAMPLE_BITS'($urandom);
            endcase
            left--;
         end else if ($urandom_range(99) == 0) begin
            x = SAMPLE_BITS'($urandom);
         end else begin
            x = SAMPLE_BITS'($signed($urandom_range(400)) - 200);
         end
         send_sample(x);
      end
   endtask

   // Extremes of the sample field through the warm-up path, then through bypass.
   task automatic test_directed();
      logic signed [SAMPLE_BITS-1:0] edges [8];
      edges = '{24'sh7FFFFF, -24'sh800000, 24'sh0, -24'sh1, 24'sh7FFFFF, 24'sh7FFFFF,
                -24'sh800000, 24'sh555555};
      foreach (edges[i]) send_sample(edges[i]);
      write_csr(CSR_ENABLE, 0);
      foreach (edges[i]) send_sample(edges[i]);
      send_sample(24'sh2AAAAA);
      write_csr(CSR_ENABLE, 1);
      send_sample(24'sh123456);
   endtask

   // Bypass with random traffic on both sides.
   task automatic test_bypass();
      send_idle_pct = 31;
      stall_pct     = 31;
      write_csr(CSR_ENABLE, 0);
      repeat (60) send_sample(SAMPLE_BITS'($urandom));
      write_csr(CSR_ENABLE, 1);
   endtask

   // Default repair limit and a mid dial, with no idling at all.
   task automatic test_repair_default();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_csr(CSR_SENSITIVITY, 128);
      write_csr(CSR_MAX_REPAIR, 32);
      send_audio(300, 100, 32);
   endtask

   // A limit below the minimum clamps to the shortest runs; the dial is above its top.
   task automatic test_short_runs();
      send_idle_pct = 49;
      stall_pct     = 0;
      write_csr(CSR_SENSITIVITY, 511);
      write_csr(CSR_MAX_REPAIR, 0);
      send_audio(200, 100, 8);
   endtask

   // The longest runs at the lowest dial, a long receiver hold-off, a full drain,
   // and a bypass burst that must leave the repair state alone.
   task automatic test_long_runs();
      send_idle_pct = 0;
      stall_pct     = 49;
      write_csr(CSR_SENSITIVITY, 0);
      write_csr(CSR_MAX_REPAIR, 255);
      send_audio(100, 100, 128);
      hold_request = 400;
      send_audio(0, 60, 128);
      drain();
      send_idle_pct = 31;
      stall_pct     = 31;
      send_audio(0, 60, 128);
      write_csr(CSR_ENABLE, 0);
      repeat (30) send_sample(SAMPLE_BITS'($urandom));
      write_csr(CSR_ENABLE, 1);
      write_csr(CSR_SENSITIVITY, 256);
      send_audio(0, 60, 128);
   endtask

   // Output side: checks each accepted item and drives a random stall, with a long
   // hold-off whenever the stimulus asks for one.
   int hold_left = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("audio_click_detect_repair_top test failed");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (repaired_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_sample_out, 0);
            end else begin
               repaired_type want;
               want = repaired_q.pop_front();
               if (rsp_sample_out !== want.sample)
                  report_mismatch("sample_out", rsp_sample_out, want.sample);
               if (rsp_repair_started !== want.started)
                  report_mismatch("repair_started", rsp_repair_started, want.started);
            end
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      cfg_enable      = 1'b1;
      cfg_sensitivity = 128;
      cfg_max_repair  = 32;
      clear_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_bypass();
      test_repair_default();
      test_short_runs();
      test_long_runs();
      drain();
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("audio_click_detect_repair_top test passed");
      end else begin
         $display("audio_click_detect_repair_top test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/acd_pkg.sv
rtl/acd_ring.sv
rtl/acd_div.sv
rtl/audio_click_detect_repair_top.sv
rtl/acd_checker.sv
tb/tb_audio_click_detect_repair_top.sv
